>>> src/rankine_core_induced_velocity_macros.svh
// Assertion macros shared by the induced velocity block.
// Taken in by the top level only; needs nothing else.
`ifndef RANKINE_CORE_INDUCED_VELOCITY_MACROS_SVH
`define RANKINE_CORE_INDUCED_VELOCITY_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RCIV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define RCIV_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/rciv_pkg.sv
// Shared types and constants of the induced velocity block.
// No dependencies; every other file except the assertion macros imports it.
`default_nettype none

package rciv_pkg;

   // round(2^32 / (2*pi))
   localparam int KW = 30;
   localparam logic [KW-1:0] INV_TWO_PI_Q32 = 30'd683565276;

   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_VORTEX_X    = 2'd0,
      REG_VORTEX_Y    = 2'd1,
      REG_CIRCULATION = 2'd2,
      REG_CORE_RADIUS = 2'd3
   } csr_reg_type;

   // Per-word status that rides along the divider pipeline.
   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic in_core;
      logic singular;
      logic ovf_x;
      logic ovf_y;
   } flag_type;

endpackage

`default_nettype wire

>>> src/rciv_ifs.sv
// Valid/ready channel interfaces: query words in, velocity words out, register writes.
// Depends on rciv_pkg.
`default_nettype none

interface rciv_req_if #(parameter int COORD_WIDTH = 32);
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] query_x;
   logic [COORD_WIDTH-1:0] query_y;
   modport source (output valid, query_x, query_y, input ready);
   modport sink (input valid, query_x, query_y, output ready);
endinterface

interface rciv_rsp_if #(parameter int COORD_WIDTH = 32);
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] vel_x;
   logic [COORD_WIDTH-1:0] vel_y;
   logic                   inside_core;
   logic                   singular;
   logic                   saturated;
   modport source (output valid, vel_x, vel_y, inside_core, singular, saturated,
                   input ready);
   modport sink (input valid, vel_x, vel_y, inside_core, singular, saturated,
                 output ready);
endinterface

interface rciv_csr_if import rciv_pkg::*; #(parameter int COORD_WIDTH = 32);
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [COORD_WIDTH-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/rciv_front.sv
// Front end: offsets, squares, products, core test and dividend setup in four stages.
// Depends on rciv_pkg.
`default_nettype none

module rciv_front import rciv_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS = 16,
   localparam int CW = COORD_WIDTH,
   localparam int DW = CW + 1,
   localparam int SW = 2 * DW + 1,
   localparam int GKW = CW + KW,
   localparam int PW = GKW + DW,
   localparam int SUMW = PW + FRAC_BITS + 2,
   localparam int AW = SUMW - 33
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [CW-1:0] query_x,
   input  wire logic [CW-1:0] query_y,
   input  wire logic [CW-1:0] vortex_x,
   input  wire logic [CW-1:0] vortex_y,
   input  wire logic [CW-1:0] circulation,
   input  wire logic [CW-2:0] core_radius,
   output logic               out_valid,
   output logic [AW-1:0]      num_x,
   output logic [AW-1:0]      num_y,
   output logic [SW-1:0]      den,
   output flag_type           flags
);

   localparam int SQW = 2 * DW;
   localparam int RSW = 2 * CW - 2;
   localparam int GLW = GKW / 2;
   localparam int GHW = GKW - GLW;
   localparam int PLW = GLW + DW;
   localparam int PHW = GHW + DW;
   localparam int QW = CW + 1;
   localparam int RW = (AW > SW + QW) ? AW : SW + QW;

   // Stage A: offsets as sign and magnitude, |G|*K, R^2.
   logic [DW-1:0]  a_dx, a_dy;
   logic [CW-1:0]  a_gm;
   logic [DW-1:0]  a_dxm_in, a_dym_in, a_dxm_ff, a_dym_ff;
   logic           a_xneg_in, a_yneg_in, a_gneg_in, a_xneg_ff, a_yneg_ff, a_gneg_ff;
   logic [GKW-1:0] a_gk_in, a_gk_ff;
   logic [RSW-1:0] a_r2_in, a_r2_ff;
   logic           a_valid_ff;

   always_comb begin
      a_dx = {query_x[CW-1], query_x} - {vortex_x[CW-1], vortex_x};
      a_dy = {query_y[CW-1], query_y} - {vortex_y[CW-1], vortex_y};
      a_xneg_in = a_dx[DW-1];
      a_yneg_in = a_dy[DW-1];
      a_dxm_in = a_xneg_in ? (~a_dx + 1'b1) : a_dx;
      a_dym_in = a_yneg_in ? (~a_dy + 1'b1) : a_dy;
      a_gneg_in = circulation[CW-1];
      a_gm = a_gneg_in ? (~circulation + 1'b1) : circulation;
      a_gk_in = GKW'(a_gm) * GKW'(INV_TWO_PI_Q32);
      a_r2_in = RSW'(core_radius) * RSW'(core_radius);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_dxm_ff  <= a_dxm_in;
         a_dym_ff  <= a_dym_in;
         a_xneg_ff <= a_xneg_in;
         a_yneg_ff <= a_yneg_in;
         a_gneg_ff <= a_gneg_in;
         a_gk_ff   <= a_gk_in;
         a_r2_ff   <= a_r2_in;
      end
   end

   // Stage B: squares and split products of |G|*K with the offset magnitudes.
   logic [SQW-1:0] b_dx2_in, b_dy2_in, b_dx2_ff, b_dy2_ff;
   logic [PLW-1:0] b_pxl_in, b_pyl_in, b_pxl_ff, b_pyl_ff;
   logic [PHW-1:0] b_pxh_in, b_pyh_in, b_pxh_ff, b_pyh_ff;
   logic           b_negx_in, b_negy_in, b_negx_ff, b_negy_ff;
   logic [RSW-1:0] b_r2_ff;
   logic           b_valid_ff;

   always_comb begin
      b_dx2_in = SQW'(a_dxm_ff) * SQW'(a_dxm_ff);
      b_dy2_in = SQW'(a_dym_ff) * SQW'(a_dym_ff);
      // vel_x scales with -dy, vel_y with dx.
      b_pxl_in = PLW'(a_gk_ff[GLW-1:0]) * PLW'(a_dym_ff);
      b_pxh_in = PHW'(a_gk_ff[GKW-1:GLW]) * PHW'(a_dym_ff);
      b_pyl_in = PLW'(a_gk_ff[GLW-1:0]) * PLW'(a_dxm_ff);
      b_pyh_in = PHW'(a_gk_ff[GKW-1:GLW]) * PHW'(a_dxm_ff);
      b_negx_in = a_gneg_ff ^ ~a_yneg_ff;
      b_negy_in = a_gneg_ff ^ a_xneg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_dx2_ff  <= b_dx2_in;
         b_dy2_ff  <= b_dy2_in;
         b_pxl_ff  <= b_pxl_in;
         b_pxh_ff  <= b_pxh_in;
         b_pyl_ff  <= b_pyl_in;
         b_pyh_ff  <= b_pyh_in;
         b_negx_ff <= b_negx_in;
         b_negy_ff <= b_negy_in;
         b_r2_ff   <= a_r2_ff;
      end
   end

   // Stage C: squared distance, core test, divisor choice.
   logic [SW-1:0] c_s;
   logic [PW-1:0] c_px_in, c_py_in, c_px_ff, c_py_ff;
   logic [SW-1:0] c_den_in, c_den_ff;
   logic          c_core_in, c_sing_in, c_core_ff, c_sing_ff;
   logic          c_negx_ff, c_negy_ff;
   logic          c_valid_ff;

   always_comb begin
      c_s = SW'(b_dx2_ff) + SW'(b_dy2_ff);
      c_px_in = (PW'(b_pxh_ff) << GLW) + PW'(b_pxl_ff);
      c_py_in = (PW'(b_pyh_ff) << GLW) + PW'(b_pyl_ff);
      c_core_in = c_s < SW'(b_r2_ff);
      c_den_in = c_core_in ? SW'(b_r2_ff) : c_s;
      c_sing_in = !c_core_in && (c_s == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_px_ff   <= c_px_in;
         c_py_ff   <= c_py_in;
         c_den_ff  <= c_den_in;
         c_core_ff <= c_core_in;
         c_sing_ff <= c_sing_in;
         c_negx_ff <= b_negx_ff;
         c_negy_ff <= b_negy_ff;
      end
   end

   // Stage D: rounded dividend. The low 33 bits of the scaled divisor are zero,
   // so they drop out of the dividend as well. Overflow is caught up front.
   logic [SUMW-1:0] d_sumx, d_sumy;
   logic [AW-1:0]   d_numx_in, d_numy_in, d_numx_ff, d_numy_ff;
   logic [SW-1:0]   d_den_ff;
   flag_type        d_flags_in, d_flags_ff;
   logic            d_valid_ff;

   always_comb begin
      d_sumx = (SUMW'(c_px_ff) << (FRAC_BITS + 1)) + (SUMW'(c_den_ff) << 32);
      d_sumy = (SUMW'(c_py_ff) << (FRAC_BITS + 1)) + (SUMW'(c_den_ff) << 32);
      d_numx_in = d_sumx[SUMW-1:33];
      d_numy_in = d_sumy[SUMW-1:33];
      d_flags_in.neg_x    = c_negx_ff;
      d_flags_in.neg_y    = c_negy_ff;
      d_flags_in.in_core  = c_core_ff;
      d_flags_in.singular = c_sing_ff;
      d_flags_in.ovf_x    = (RW'(d_numx_in) >> QW) >= RW'(c_den_ff);
      d_flags_in.ovf_y    = (RW'(d_numy_in) >> QW) >= RW'(c_den_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_numx_ff  <= d_numx_in;
         d_numy_ff  <= d_numy_in;
         d_den_ff   <= c_den_ff;
         d_flags_ff <= d_flags_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign num_x     = d_numx_ff;
   assign num_y     = d_numy_ff;
   assign den       = d_den_ff;
   assign flags     = d_flags_ff;

endmodule

`default_nettype wire

>>> src/rciv_divider.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes on one divisor.
// Depends on rciv_pkg.
`default_nettype none

module rciv_divider import rciv_pkg::*; #(
   parameter int AW = 80,
   parameter int SW = 67,
   parameter int QW = 33,
   localparam int RW = (AW > SW + QW) ? AW : SW + QW
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [AW-1:0] num_x,
   input  wire logic [AW-1:0] num_y,
   input  wire logic [SW-1:0] den,
   input  wire flag_type      flags_in,
   output logic               out_valid,
   output logic [QW-1:0]      quot_x,
   output logic [QW-1:0]      quot_y,
   output flag_type           flags_out
);

   logic [RW-1:0] rem_x_ff [QW];
   logic [RW-1:0] rem_y_ff [QW];
   logic [SW-1:0] den_ff [QW];
   logic [QW-1:0] q_x_ff [QW];
   logic [QW-1:0] q_y_ff [QW];
   flag_type      flg_ff [QW];
   logic          vld_ff [QW];

   logic [RW-1:0] rem_x_in [QW];
   logic [RW-1:0] rem_y_in [QW];
   logic [SW-1:0] den_in [QW];
   logic [QW-1:0] q_x_in [QW];
   logic [QW-1:0] q_y_in [QW];
   flag_type      flg_in [QW];
   logic          vld_in [QW];

   // Stage k decides quotient bit QW-1-k against the divisor shifted to match.
   always_comb begin
      logic [RW-1:0] rx, ry;
      logic [SW-1:0] dn;
      logic [QW-1:0] qx, qy;
      logic [RW:0]   sh, tx, ty;
      for (int k = 0; k < QW; k++) begin
         if (k == 0) begin
            rx = RW'(num_x);
            ry = RW'(num_y);
            dn = den;
            qx = '0;
            qy = '0;
            flg_in[k] = flags_in;
            vld_in[k] = in_valid;
         end else begin
            rx = rem_x_ff[k-1];
            ry = rem_y_ff[k-1];
            dn = den_ff[k-1];
            qx = q_x_ff[k-1];
            qy = q_y_ff[k-1];
            flg_in[k] = flg_ff[k-1];
            vld_in[k] = vld_ff[k-1];
         end
         sh = (RW + 1)'(dn) << (QW - 1 - k);
         tx = {1'b0, rx} - sh;
         ty = {1'b0, ry} - sh;
         rem_x_in[k] = tx[RW] ? rx : tx[RW-1:0];
         rem_y_in[k] = ty[RW] ? ry : ty[RW-1:0];
         q_x_in[k] = {qx[QW-2:0], ~tx[RW]};
         q_y_in[k] = {qy[QW-2:0], ~ty[RW]};
         den_in[k] = dn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QW; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         den_ff   <= den_in;
         q_x_ff   <= q_x_in;
         q_y_ff   <= q_y_in;
         flg_ff   <= flg_in;
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign quot_x    = q_x_ff[QW-1];
   assign quot_y    = q_y_ff[QW-1];
   assign flags_out = flg_ff[QW-1];

endmodule

`default_nettype wire

>>> src/rankine_core_induced_velocity.sv
// Top level of the Rankine-core induced velocity block: registers, pipeline, output stage.
// Depends on rciv_pkg, rciv_ifs, rciv_front, rciv_divider and the assertion macros.
`default_nettype none
`include "rankine_core_induced_velocity_macros.svh"

// Computes the velocity that one regularized point vortex induces at each query point.
// One query word is taken every cycle while the result side is not stalled. Each word passes
// through COORD_WIDTH + 6 register stages (38 at the default width): four front-end stages,
// a divider of COORD_WIDTH + 1 stages that resolves one quotient bit per stage, and the
// output register. When the result side stalls, the whole pipeline holds and the query
// side sees ready low.
// Register writes are always accepted and must only be issued while no word is in flight.

module rankine_core_induced_velocity import rciv_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   rciv_req_if.sink   req_bus,
   rciv_rsp_if.source rsp_bus,
   rciv_csr_if.sink   csr_bus
);

   localparam int CW = COORD_WIDTH;
   localparam int DW = CW + 1;
   localparam int SW = 2 * DW + 1;
   localparam int PW = CW + KW + DW;
   localparam int AW = PW + FRAC_BITS + 2 - 33;
   localparam int QW = CW + 1;
   localparam logic [QW-1:0] BND_NEG = QW'(1) << (CW - 1);
   localparam logic [QW-1:0] BND_POS = BND_NEG - 1'b1;

   logic [CW-1:0] vortex_x_ff, vortex_y_ff, circulation_ff;
   logic [CW-2:0] core_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vortex_x_ff    <= '0;
         vortex_y_ff    <= '0;
         circulation_ff <= '0;
         core_radius_ff <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_reg_type'(csr_bus.index))
            REG_VORTEX_X:    vortex_x_ff    <= csr_bus.data;
            REG_VORTEX_Y:    vortex_y_ff    <= csr_bus.data;
            REG_CIRCULATION: circulation_ff <= csr_bus.data;
            REG_CORE_RADIUS: core_radius_ff <= csr_bus.data[CW-2:0];
            default: ;
         endcase
      end
   end

   assign csr_bus.ready = 1'b1;

   logic out_valid_ff;
   logic advance;

   // Every stage moves together whenever the output register can take a word.
   assign advance = rsp_bus.ready || !out_valid_ff;
   assign req_bus.ready = advance;

   logic          fe_valid;
   logic [AW-1:0] fe_num_x, fe_num_y;
   logic [SW-1:0] fe_den;
   flag_type      fe_flags;

   rciv_front #(
      .COORD_WIDTH(CW),
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (advance),
      .in_valid    (req_bus.valid),
      .query_x     (req_bus.query_x),
      .query_y     (req_bus.query_y),
      .vortex_x    (vortex_x_ff),
      .vortex_y    (vortex_y_ff),
      .circulation (circulation_ff),
      .core_radius (core_radius_ff),
      .out_valid   (fe_valid),
      .num_x       (fe_num_x),
      .num_y       (fe_num_y),
      .den         (fe_den),
      .flags       (fe_flags)
   );

   logic          dv_valid;
   logic [QW-1:0] dv_qx, dv_qy;
   flag_type      dv_flags;

   rciv_divider #(
      .AW(AW),
      .SW(SW),
      .QW(QW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (fe_valid),
      .num_x     (fe_num_x),
      .num_y     (fe_num_y),
      .den       (fe_den),
      .flags_in  (fe_flags),
      .out_valid (dv_valid),
      .quot_x    (dv_qx),
      .quot_y    (dv_qy),
      .flags_out (dv_flags)
   );

   // Output stage: clip to the signed range, apply the sign, force the singular case.
   logic [QW-1:0] bnd_x, bnd_y, mag_x, mag_y, val_x, val_y;
   logic          sat_x, sat_y;
   logic [CW-1:0] vel_x_in, vel_y_in, vel_x_ff, vel_y_ff;
   logic          sat_in, sat_ff, core_ff, sing_ff;

   always_comb begin
      bnd_x = dv_flags.neg_x ? BND_NEG : BND_POS;
      bnd_y = dv_flags.neg_y ? BND_NEG : BND_POS;
      sat_x = dv_flags.ovf_x || (dv_qx > bnd_x);
      sat_y = dv_flags.ovf_y || (dv_qy > bnd_y);
      mag_x = sat_x ? bnd_x : dv_qx;
      mag_y = sat_y ? bnd_y : dv_qy;
      val_x = dv_flags.neg_x ? (~mag_x + 1'b1) : mag_x;
      val_y = dv_flags.neg_y ? (~mag_y + 1'b1) : mag_y;
      if (dv_flags.singular) begin
         vel_x_in = '0;
         vel_y_in = '0;
         sat_in = 1'b0;
      end else begin
         vel_x_in = val_x[CW-1:0];
         vel_y_in = val_y[CW-1:0];
         sat_in = sat_x || sat_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vel_x_ff <= vel_x_in;
         vel_y_ff <= vel_y_in;
         sat_ff   <= sat_in;
         core_ff  <= dv_flags.in_core;
         sing_ff  <= dv_flags.singular;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.vel_x       = vel_x_ff;
   assign rsp_bus.vel_y       = vel_y_ff;
   assign rsp_bus.inside_core = core_ff;
   assign rsp_bus.singular    = sing_ff;
   assign rsp_bus.saturated   = sat_ff;

   `RCIV_ASSERT_IMP(a_singular_zero, clock, reset, rsp_bus.valid && rsp_bus.singular,
      rsp_bus.vel_x == '0 && rsp_bus.vel_y == '0 && !rsp_bus.saturated &&
      !rsp_bus.inside_core, "singular word carries velocity or flags")
   `RCIV_ASSERT_IMP(a_backpressure, clock, reset, rsp_bus.valid && !rsp_bus.ready,
      !req_bus.ready, "query taken while output is stalled")
   `RCIV_ASSERT_NXT(a_circ_write, clock, reset,
      csr_bus.valid && csr_bus.index == REG_CIRCULATION,
      circulation_ff == $past(csr_bus.data), "circulation write lost")

endmodule

`default_nettype wire
